@@ rtl/core/mwfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mwfr_pkg
// Shared types and constants for the magic word frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mwfr_pkg;

    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned MAGIC_W     = 32;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned TICK_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIMEOUT = 2'd2;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET   = {8'h50, 8'h49, 8'h4D, 8'h47};
    localparam logic [LEN_W-1:0]   LENGTH_RESET  = 16'd9216;
    localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 24'd2000000;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic signed [7:0] pixel;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic       is_tick;
        logic       eq_first;
        logic [7:0] data;
    } t_event;

    typedef enum logic {
        MODE_HUNT,
        MODE_RECV
    } t_mode;

endpackage

`default_nettype wire

@@ rtl/core/mwfr_front.sv @@
// ----------------------------------------------------------------------------
// mwfr_front
// Input stage: registers each transaction and classifies it as byte or tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mwfr_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire mwfr_pkg::t_in_item  i_in_data,
    input  wire logic [7:0]          i_magic_first,
    output logic                     o_evt_valid,
    output mwfr_pkg::t_event         o_evt,
    input  wire logic                i_evt_ready
);
    import mwfr_pkg::*;

    logic   r_valid;
    t_event r_evt;

    assign o_in_ready  = !r_valid || i_evt_ready;
    assign o_evt_valid = r_valid;
    assign o_evt       = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_evt.is_tick  <= (i_in_data.action == ACT_TICK);
            r_evt.eq_first <= (i_in_data.rx_byte == i_magic_first);
            r_evt.data     <= i_in_data.rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mwfr_queue.sv @@
// ----------------------------------------------------------------------------
// mwfr_queue
// Two-entry event queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mwfr_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mwfr_pkg::t_event  i_push_data,
    output logic                   o_not_full,
    output logic                   o_valid,
    output mwfr_pkg::t_event       o_data,
    input  wire logic              i_pop
);
    import mwfr_pkg::*;

    t_event      r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push_ok;
    logic        pop_ok;

    assign o_not_full = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];
    assign push_ok    = i_push && o_not_full;
    assign pop_ok     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mwfr_back.sv @@
// ----------------------------------------------------------------------------
// mwfr_back
// Deframer state machine: hunts the magic word, passes payload bytes out,
// aborts a frame on idle timeout. Holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwfr_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [mwfr_pkg::MAGIC_W-1:0] i_magic_word,
    input  wire logic [mwfr_pkg::LEN_W-1:0]   i_frame_length,
    input  wire logic [mwfr_pkg::TICK_W-1:0]  i_timeout,
    input  wire logic                         i_evt_valid,
    input  wire mwfr_pkg::t_event             i_evt,
    output logic                              o_evt_pop,
    output logic                              o_out_valid,
    output mwfr_pkg::t_out_item               o_out_data,
    input  wire logic                         i_out_ready
);
    import mwfr_pkg::*;

    t_mode              r_mode;
    t_mode              n_mode;
    logic [1:0]         r_match;
    logic [1:0]         n_match;
    logic [LEN_W-1:0]   r_bytes;
    logic [LEN_W-1:0]   n_bytes;
    logic [TICK_W-1:0]  r_idle;
    logic [TICK_W-1:0]  n_idle;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               emit;
    t_out_item          emit_data;
    logic [7:0]         magic_byte;
    logic [TICK_W-1:0]  idle_inc;
    logic [LEN_W-1:0]   bytes_inc;

    assign o_evt_pop   = i_evt_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign idle_inc    = r_idle + TICK_W'(1);
    assign bytes_inc   = r_bytes + LEN_W'(1);

    always_comb begin
        unique case (r_match)
            2'd0:    magic_byte = i_magic_word[31:24];
            2'd1:    magic_byte = i_magic_word[23:16];
            2'd2:    magic_byte = i_magic_word[15:8];
            default: magic_byte = i_magic_word[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_match <= 2'd0;
            r_bytes <= '0;
            r_idle  <= '0;
        end else if (o_evt_pop) begin
            r_mode  <= n_mode;
            r_match <= n_match;
            r_bytes <= n_bytes;
            r_idle  <= n_idle;
        end
    end

    always_comb begin
        n_mode          = r_mode;
        n_match         = r_match;
        n_bytes         = r_bytes;
        n_idle          = r_idle;
        emit            = 1'b0;
        emit_data.kind  = KIND_PIXEL;
        emit_data.pixel = $signed(i_evt.data);
        emit_data.last  = 1'b0;
        unique case (r_mode)
            MODE_HUNT: begin
                if (!i_evt.is_tick) begin
                    if (i_evt.data == magic_byte) begin
                        n_match = r_match + 2'd1;
                        if (r_match == 2'd3) begin
                            n_match = 2'd0;
                            n_bytes = '0;
                            n_idle  = '0;
                            n_mode  = (i_frame_length != '0) ? MODE_RECV : MODE_HUNT;
                        end
                    end else begin
                        n_match = i_evt.eq_first ? 2'd1 : 2'd0;
                    end
                end
            end
            MODE_RECV: begin
                if (i_evt.is_tick) begin
                    n_idle = idle_inc;
                    if (idle_inc >= i_timeout) begin
                        n_mode          = MODE_HUNT;
                        n_match         = 2'd0;
                        n_bytes         = '0;
                        n_idle          = '0;
                        emit            = 1'b1;
                        emit_data.kind  = KIND_ABORT;
                        emit_data.pixel = '0;
                    end
                end else begin
                    n_idle         = '0;
                    n_bytes        = bytes_inc;
                    emit           = 1'b1;
                    emit_data.last = (bytes_inc == '0) || (bytes_inc >= i_frame_length);
                    if (emit_data.last) begin
                        n_mode  = MODE_HUNT;
                        n_match = 2'd0;
                        n_bytes = '0;
                    end
                end
            end
            default: begin
                n_mode = MODE_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_evt_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_evt_pop && emit) begin
            r_out <= emit_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/magic_word_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// magic_word_frame_receiver
// Serial deframer: finds a four-byte magic word, then passes the frame's
// payload bytes out as signed pixels; aborts a frame on byte timeout.
//
// Input channel (i_in_valid / o_in_ready, i_in_data): one transaction is a
// received byte (action 0) or one elapsed tick (action 1).
// Output channel (o_out_valid / i_out_ready, o_out_data): a payload pixel
// with a last mark on the final byte, or an abort marker after a timeout.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 magic word, 1 frame length, 2 byte timeout); write only while idle.
// Throughput: one transaction per cycle while the receiver takes its results,
// set by the state update in the back end. Path: a result passes through the
// input register, the queue and the output register, in that order.
// Reset: returns to hunting, empties the queue and output register and
// loads the default magic word, frame length and timeout.
// Receiver stall: the output register holds its result; the two-entry queue
// and the input register absorb up to three more transactions before
// o_in_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_word_frame_receiver (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire mwfr_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output mwfr_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [mwfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mwfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mwfr_pkg::*;

    logic [MAGIC_W-1:0] r_magic;
    logic [LEN_W-1:0]   r_length;
    logic [TICK_W-1:0]  r_timeout;

    logic   front_valid;
    t_event front_evt;
    logic   q_not_full;
    logic   q_valid;
    t_event q_evt;
    logic   q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_length  <= LENGTH_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAGIC_WORD:   r_magic   <= i_cfg_data[MAGIC_W-1:0];
                CFG_FRAME_LENGTH: r_length  <= i_cfg_data[LEN_W-1:0];
                CFG_BYTE_TIMEOUT: r_timeout <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mwfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_magic_first (r_magic[31:24]),
        .o_evt_valid   (front_valid),
        .o_evt         (front_evt),
        .i_evt_ready   (q_not_full)
    );

    mwfr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_push_data (front_evt),
        .o_not_full  (q_not_full),
        .o_valid     (q_valid),
        .o_data      (q_evt),
        .i_pop       (q_pop)
    );

    mwfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_magic_word   (r_magic),
        .i_frame_length (r_length),
        .i_timeout      (r_timeout),
        .i_evt_valid    (q_valid),
        .i_evt          (q_evt),
        .o_evt_pop      (q_pop),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data),
        .i_out_ready    (i_out_ready)
    );

    a_abort_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_ABORT) |->
            (o_out_data.last == 1'b0 && o_out_data.pixel == 8'sd0))
        else $error("abort result carries pixel data");

    a_stall_needs_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (front_valid && !q_not_full))
        else $error("input stalled without a full queue");

    a_queue_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !q_pop) |=> q_valid)
        else $error("queue dropped an entry");

endmodule

`default_nettype wire

@@ test/mwfr_frame_checker.sv @@
// ----------------------------------------------------------------------------
// mwfr_frame_checker
// Watches the input, output and register ports of the magic word frame
// receiver. Each accepted input transaction updates a local model of the
// deframer (sync hunt, payload count, idle tick count), and every result that
// model produces is queued. Accepted output transactions are compared field
// by field with the oldest queued result. The failure count and the number of
// results still outstanding go to the testbench top.
// ----------------------------------------------------------------------------
module mwfr_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  mwfr_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  mwfr_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_we,
    input  logic [mwfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mwfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_pixels,
    output int                              o_frame_ends,
    output int                              o_aborts
);
    timeunit 1ns;
    timeprecision 1ps;

    import mwfr_pkg::*;

    logic [MAGIC_W-1:0] magic_cfg;
    logic [LEN_W-1:0]   frame_len_cfg;
    logic [TICK_W-1:0]  timeout_cfg;

    t_mode              mode;
    logic [2:0]         match_cnt;
    logic [LEN_W-1:0]   rx_count;
    logic [TICK_W-1:0]  idle_count;

    t_out_item          pixel_abort_q[$];
    t_out_item          want;
    t_out_item          new_res;

    function automatic logic [7:0] sync_byte(input logic [2:0] pos);
        logic [MAGIC_W-1:0] shifted;
        shifted = magic_cfg >> (8 * (3 - pos[1:0]));
        return shifted[7:0];
    endfunction

    function automatic void resume_hunt();
        mode       = MODE_HUNT;
        match_cnt  = '0;
        rx_count   = '0;
        idle_count = '0;
    endfunction

    function automatic bit deframe_step(input t_in_item item, output t_out_item res);
        res = '0;
        if (item.action == ACT_TICK) begin
            if (mode == MODE_HUNT) begin
                return 1'b0;
            end
            idle_count = idle_count + 1'b1;
            if (idle_count >= timeout_cfg) begin
                resume_hunt();
                res.kind = KIND_ABORT;
                return 1'b1;
            end
            return 1'b0;
        end
        if (mode == MODE_HUNT) begin
            if (item.rx_byte == sync_byte(match_cnt)) begin
                match_cnt = match_cnt + 1'b1;
            end else begin
                match_cnt = (item.rx_byte == sync_byte(3'd0)) ? 3'd1 : 3'd0;
            end
            if (match_cnt >= 3'd4) begin
                resume_hunt();
                if (frame_len_cfg != '0) begin
                    mode = MODE_RECV;
                end
            end
            return 1'b0;
        end
        idle_count = '0;
        rx_count   = rx_count + 1'b1;
        res.kind   = KIND_PIXEL;
        res.pixel  = item.rx_byte;
        res.last   = (rx_count == '0) || (rx_count >= frame_len_cfg);
        if (res.last) begin
            resume_hunt();
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            magic_cfg     = MAGIC_RESET;
            frame_len_cfg = LENGTH_RESET;
            timeout_cfg   = TIMEOUT_RESET;
            resume_hunt();
            pixel_abort_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_pixels     = 0;
            o_frame_ends = 0;
            o_aborts     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC_WORD:   magic_cfg     = i_cfg_data[MAGIC_W-1:0];
                    CFG_FRAME_LENGTH: frame_len_cfg = i_cfg_data[LEN_W-1:0];
                    CFG_BYTE_TIMEOUT: timeout_cfg   = i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pixel_abort_q.size() == 0) begin
                    o_fail_count++;
                    $error("unexpected result: kind %0d pixel %0d last %0d",
                           i_out_data.kind, i_out_data.pixel, i_out_data.last);
                end else begin
                    want = pixel_abort_q.pop_front();
                    if (i_out_data.kind !== want.kind) begin
                        o_fail_count++;
                        $error("kind: expected %0d, actual %0d", want.kind, i_out_data.kind);
                    end
                    if (i_out_data.pixel !== want.pixel) begin
                        o_fail_count++;
                        $error("pixel: expected %0d, actual %0d", want.pixel, i_out_data.pixel);
                    end
                    if (i_out_data.last !== want.last) begin
                        o_fail_count++;
                        $error("last: expected %0d, actual %0d", want.last, i_out_data.last);
                    end
                    if (want.kind == KIND_ABORT) begin
                        o_aborts++;
                    end else begin
                        o_pixels++;
                        if (want.last) begin
                            o_frame_ends++;
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (deframe_step(i_in_data, new_res)) begin
                    pixel_abort_q.push_back(new_res);
                end
            end
            o_pending = pixel_abort_q.size();
        end
    end

endmodule

@@ test/tb_magic_word_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// tb_magic_word_frame_receiver
// Drives byte and tick transactions into the magic word frame receiver under
// several register settings and idle/stall mixes: a short directed part for
// sync restarts, pixel extremes, empty frames, zero and extreme timeouts and a
// frame length lowered mid-frame, then randomized sync sequences with random
// payload, broken syncs and noise. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_magic_word_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import mwfr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETS_PER_MIX  = 8;
    localparam int ITEMS_PER_SET = 60;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int pixels;
    int frame_ends;
    int aborts;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int settings_used = 0;
    int cycle_count   = 0;

    logic [MAGIC_W-1:0] cur_magic   = MAGIC_RESET;
    logic [LEN_W-1:0]   cur_len     = LENGTH_RESET;
    logic [TICK_W-1:0]  cur_timeout = TIMEOUT_RESET;

    magic_word_frame_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    mwfr_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pixels     (pixels),
        .o_frame_ends (frame_ends),
        .o_aborts     (aborts)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_magic_word_frame_receiver: errors");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input logic action, input logic [7:0] value);
        t_in_item item;
        item.action  = action;
        item.rx_byte = value;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, 8'($urandom));
    endtask

    task automatic send_sync(input bit corrupt);
        int         bad_pos;
        logic [7:0] b;
        bad_pos = corrupt ? $urandom_range(3) : 4;
        for (int k = 0; k < 4; k++) begin
            b = cur_magic[8 * (3 - k) +: 8];
            if (k == bad_pos) begin
                b = b ^ 8'($urandom_range(255, 1));
            end
            send_item(ACT_BYTE, b);
        end
    endtask

    // hold the sender off until every queued result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [MAGIC_W-1:0] magic,
                                 input logic [LEN_W-1:0] len,
                                 input logic [TICK_W-1:0] tmo);
        write_reg(CFG_MAGIC_WORD, magic);
        write_reg(CFG_FRAME_LENGTH, ($urandom & 32'hFFFF_0000) | {16'h0, len});
        write_reg(CFG_BYTE_TIMEOUT, ($urandom & 32'hFF00_0000) | {8'h0, tmo});
        cur_magic   = magic;
        cur_len     = len;
        cur_timeout = tmo;
        settings_used++;
    endtask

    task automatic run_random_set();
        int                 target;
        int                 pick;
        int                 cut;
        int                 abort_at;
        int                 gap_max;
        logic [7:0]         a;
        logic [7:0]         c;
        logic [MAGIC_W-1:0] magic;
        logic [LEN_W-1:0]   len;
        logic [TICK_W-1:0]  tmo;
        drain();
        a = 8'($urandom);
        c = 8'($urandom);
        case ($urandom_range(3))
            0:       magic = $urandom;
            1:       magic = {4{a}};
            2:       magic = {a, a, c, a};
            default: magic = {a, c, a, c};
        endcase
        pick = $urandom_range(99);
        if (pick < 5) begin
            len = '0;
        end else if (pick < 12) begin
            len = LEN_W'($urandom_range(200, 20));
        end else begin
            len = LEN_W'($urandom_range(12, 1));
        end
        pick = $urandom_range(99);
        if (pick < 5) begin
            tmo = '0;
        end else if (pick < 12) begin
            tmo = TICK_W'($urandom);
        end else begin
            tmo = TICK_W'($urandom_range(8, 1));
        end
        apply_setting(magic, len, tmo);
        target = items_sent + ITEMS_PER_SET;
        while (items_sent < target) begin
            if ($urandom_range(99) < 75) begin
                repeat ($urandom_range(2)) send_item(ACT_BYTE, 8'($urandom));
                send_sync($urandom_range(9) == 0);
                cut      = (cur_len > 40) ? 40 : cur_len;
                abort_at = ($urandom_range(99) < 15 && cur_timeout <= 8)
                           ? $urandom_range(cut) : -1;
                gap_max  = (cur_timeout > 6) ? 5 : int'(cur_timeout) - 1;
                for (int k = 0; k < cut; k++) begin
                    if (k == abort_at) begin
                        repeat ((cur_timeout == 0) ? 1 : cur_timeout) send_tick();
                        break;
                    end
                    if (gap_max > 0 && $urandom_range(99) < 30) begin
                        repeat ($urandom_range(gap_max)) send_tick();
                    end
                    send_item(ACT_BYTE, 8'($urandom));
                end
            end else if ($urandom_range(1) == 0) begin
                repeat ($urandom_range(6, 1)) send_item(1'($urandom), 8'($urandom));
            end else begin
                // broken sync: a leading part of the word, then anything
                pick = $urandom_range(3, 1);
                for (int k = 0; k < pick; k++) begin
                    send_item(ACT_BYTE, cur_magic[8 * (3 - k) +: 8]);
                end
                send_item(1'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sync word: tick while hunting, restart on the first byte
        send_tick();
        send_item(ACT_BYTE, cur_magic[31:24]);
        send_item(ACT_BYTE, cur_magic[23:16]);
        send_sync(1'b0);
        send_item(ACT_BYTE, 8'h80);
        send_item(ACT_BYTE, 8'h7F);
        send_tick();
        drain();
        write_reg(CFG_FRAME_LENGTH, 32'd2);
        cur_len = 16'd2;
        send_item(ACT_BYTE, 8'h5A);

        // repeated sync bytes, single-byte frames, one-tick timeout
        drain();
        apply_setting(32'hFFFF_FFFF, 16'd1, 24'd1);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'hFE);
        send_sync(1'b0);
        send_item(ACT_BYTE, 8'h00);
        send_sync(1'b0);
        send_tick();

        // empty frame, then a zero timeout
        drain();
        apply_setting(32'h0000_0000, 16'd0, 24'd0);
        send_sync(1'b0);
        drain();
        write_reg(CFG_FRAME_LENGTH, 32'd2);
        cur_len = 16'd2;
        send_sync(1'b0);
        send_tick();
        drain();
        write_reg(CFG_UNMAPPED, $urandom);

        // widest length and timeout, then cut the open frame short
        apply_setting($urandom, 16'hFFFF, 24'hFF_FFFF);
        send_sync(1'b0);
        send_item(ACT_BYTE, 8'hFF);
        send_tick();
        send_item(ACT_BYTE, 8'h01);
        drain();
        write_reg(CFG_FRAME_LENGTH, 32'd1);
        cur_len = 16'd1;
        send_item(ACT_BYTE, 8'hC3);

        for (int mix = 0; mix < 4; mix++) begin
            drain();
            case (mix)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 87;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 87;
                end
                default: begin
                    send_idle_pct = 38;
                    stall_pct     = 38;
                end
            endcase
            repeat (SETS_PER_MIX) run_random_set();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        drain();

        $display("Covered %0d input transactions over %0d register settings and four idle mixes.",
                 items_sent, settings_used);
        $display("Checked %0d pixels, %0d frame ends and %0d timeout aborts.",
                 pixels, frame_ends, aborts);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_magic_word_frame_receiver: clean");
        end else begin
            $display("tb_magic_word_frame_receiver: errors");
        end
        $finish;
    end

endmodule
